/* rtl/qrs_pkg.sv */
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int KIND_W         = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALL     = 3'd0,
    KIND_NONE    = 3'd1,
    KIND_LINEAR  = 3'd2,
    KIND_DOUBLE  = 3'd3,
    KIND_TWO     = 3'd4,
    KIND_COMPLEX = 3'd5
  } kind_t;

endpackage

/* rtl/qrs_if.sv */
interface qrs_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/qrs_sqrt_cell.sv */
// One digit of a restoring integer square root, registered.
module qrs_sqrt_cell #(
  parameter int NW = 64,
  parameter int RW = 32,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  output logic [NW-1:0] rem_o,
  output logic [RW-1:0] root_o
);
  localparam int SH = 2 * (RW - 1 - STEP);

  logic [NW+1:0] trial;
  logic [NW+1:0] rem_sh;
  logic [NW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;

  always_comb begin
    rem_sh   = {2'b00, rem_i} >> SH;
    trial    = {{(NW+2-RW-2){1'b0}}, root_i, 2'b01};
    rem_nxt  = rem_i;
    root_nxt = root_i << 1;
    if (rem_sh >= trial) begin
      rem_nxt  = NW'(({2'b00, rem_i}) - (trial << SH));
      root_nxt = (root_i << 1) | RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end
endmodule

/* rtl/qrs_div_cell.sv */
// One quotient bit of a restoring divider, with the divisor carried alongside.
module qrs_div_cell #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o
);
  logic [DW:0]   shifted;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] num_nxt;

  always_comb begin
    shifted = {rem_i, num_i[NW-1-STEP]};
    num_nxt = num_i;
    if (shifted >= {1'b0, den_i}) begin
      rem_nxt = DW'(shifted - {1'b0, den_i});
      num_nxt[NW-1-STEP] = 1'b1;
    end else begin
      rem_nxt = DW'(shifted);
      num_nxt[NW-1-STEP] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= num_nxt;
      den_o <= den_i;
      rem_o <= rem_nxt;
    end
  end
endmodule

/* rtl/quadratic_root_solver.sv */
// Quadratic root solver: a*x^2 + b*x + c = 0 over signed fixed-point coefficients.
// Input channel (in_): one beat carries coef_a, coef_b, coef_c, packed a|b|c.
// Output channel (out_): one beat carries solution_kind, root_one, root_two,
// overflow, packed kind|r1|r2|ovf.
// The datapath is a chain of cells: one register stage for decode, two for
// the exact discriminant (products, then add), one cell per root digit of the
// square root, one stage to form the numerators, then two parallel chains of
// divider cells (one quotient bit per cell) and a final saturation stage that
// loads the output register.
// Coefficients and roots default to Q16.16; throughput is one beat per cycle
// while the receiver keeps taking results.
// The whole pipe advances only when the output register is empty or being
// taken, so a stalled receiver freezes every stage and in_ready drops; no beat
// is ever dropped. Reset clears the per-stage valid bits only.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  qrs_if.sink   in_ch,
  qrs_if.source out_ch
);
  localparam int CW  = COEF_WIDTH;
  localparam int PW  = 2 * CW + 3;            // |d| width
  localparam int RW  = (PW + 1) / 2;          // sqrt width
  localparam int MW  = (RW > CW ? RW : CW) + 1; // numerator magnitude
  localparam int NW  = MW + FRAC_BITS;        // dividend width
  localparam int DW  = CW + 2;                // divisor 2|a| width
  localparam int SQN = RW;
  localparam int DVN = NW;
  localparam int LAT = 3 + SQN + 1 + DVN;

  // pipeline enable: advance when output free
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // per-stage valid chain
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // sideband record carried through the discriminant and square-root stages
  typedef struct packed {
    kind_t        kind;
    logic         sa;
    logic         sb;
    logic [CW-1:0] mb;
    logic [CW-1:0] ma;
  } side_t;

  // stage 0: decode
  logic signed [CW-1:0] a_in, b_in, c_in;
  assign a_in = in_ch.data[3*CW-1:2*CW];
  assign b_in = in_ch.data[2*CW-1:CW];
  assign c_in = in_ch.data[CW-1:0];

  logic [CW-1:0] ma0_r, mb0_r, mc0_r;
  logic sa0_r, sb0_r, sc0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa0_r <= a_in[CW-1]; sb0_r <= b_in[CW-1]; sc0_r <= c_in[CW-1];
      ma0_r <= a_in[CW-1] ? CW'(-a_in) : a_in;
      mb0_r <= b_in[CW-1] ? CW'(-b_in) : b_in;
      mc0_r <= c_in[CW-1] ? CW'(-c_in) : c_in;
    end
  end
  // note: magnitude of most negative value is 2^(CW-1), fits CW unsigned

  // stage 1: products
  logic [2*CW-1:0] bb1_r, ac1_r;
  logic [CW-1:0] ma1_r, mb1_r, mc1_r;
  logic sa1_r, sb1_r, sc1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      bb1_r <= mb0_r * mb0_r;
      ac1_r <= ma0_r * mc0_r;
      ma1_r <= ma0_r; mb1_r <= mb0_r; mc1_r <= mc0_r;
      sa1_r <= sa0_r; sb1_r <= sb0_r; sc1_r <= sc0_r;
    end
  end

  // stage 2: discriminant and case
  logic [PW-1:0] bbw, facw, dmag;
  logic dneg;
  kind_t kind2;
  always_comb begin
    bbw  = PW'(bb1_r);
    facw = PW'(ac1_r) << 2;
    dneg = 1'b0;
    if (sa1_r != sc1_r || mc1_r == '0) dmag = bbw + facw;
    else if (bbw >= facw) dmag = bbw - facw;
    else begin
      dmag = facw - bbw;
      dneg = 1'b1;
    end
    if (ma1_r == '0) begin
      if (mb1_r == '0) kind2 = (mc1_r == '0) ? KIND_ALL : KIND_NONE;
      else kind2 = KIND_LINEAR;
    end else if (dmag == '0) kind2 = KIND_DOUBLE;
    else if (!dneg) kind2 = KIND_TWO;
    else kind2 = KIND_COMPLEX;
  end

  side_t side2_r;
  logic [PW-1:0] dmag2_r;
  logic [CW-1:0] mc2_r;
  logic sc2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= '{kind: kind2, sa: sa1_r, sb: sb1_r, mb: mb1_r, ma: ma1_r};
      dmag2_r <= dmag;
      mc2_r   <= mc1_r;
      sc2_r   <= sc1_r;
    end
  end

  // square root chain
  localparam int SNW = 2 * RW;
  logic [SNW-1:0] srem [SQN+1];
  logic [RW-1:0]  sroot [SQN+1];
  side_t          sside [SQN+1];
  logic [CW-1:0]  smc [SQN+1];
  logic           ssc [SQN+1];
  assign srem[0]  = SNW'(dmag2_r);
  assign sroot[0] = '0;
  assign sside[0] = side2_r;
  assign smc[0]   = mc2_r;
  assign ssc[0]   = sc2_r;

  for (genvar i = 0; i < SQN; i++) begin : g_sq
    qrs_sqrt_cell #(.NW(SNW), .RW(RW), .STEP(i)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(srem[i]), .root_i(sroot[i]),
      .rem_o(srem[i+1]), .root_o(sroot[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sside[i+1] <= sside[i];
        smc[i+1]   <= smc[i];
        ssc[i+1]   <= ssc[i];
      end
    end
  end

  // numerator stage: signed-magnitude sums
  side_t sd;
  logic [RW-1:0] s;
  logic nbneg;
  logic [MW-1:0] n1, n2;
  logic ng1, ng2;
  logic [DW-1:0] den;
  always_comb begin
    sd    = sside[SQN];
    s     = sroot[SQN];
    nbneg = !sd.sb && sd.mb != '0;   // numerator sign of -b
    den   = DW'({sd.ma, 1'b0});
    n1 = '0; ng1 = 1'b0; n2 = '0; ng2 = 1'b0;
    case (sd.kind)
      KIND_LINEAR: begin
        n1 = MW'(smc[SQN]); ng1 = !ssc[SQN] && smc[SQN] != '0;
        den = DW'(sd.mb);
      end
      KIND_DOUBLE: begin
        n1 = MW'(sd.mb); ng1 = nbneg;
      end
      KIND_TWO: begin
        // -b + s
        if (!nbneg) begin
          n1 = MW'(sd.mb) + MW'(s); ng1 = 1'b0;
        end else if (MW'(sd.mb) >= MW'(s)) begin
          n1 = MW'(sd.mb) - MW'(s); ng1 = 1'b1;
        end else begin
          n1 = MW'(s) - MW'(sd.mb); ng1 = 1'b0;
        end
        // -b - s
        if (nbneg) begin
          n2 = MW'(sd.mb) + MW'(s); ng2 = 1'b1;
        end else if (MW'(sd.mb) >= MW'(s)) begin
          n2 = MW'(sd.mb) - MW'(s); ng2 = 1'b0;
        end else begin
          n2 = MW'(s) - MW'(sd.mb); ng2 = 1'b1;
        end
        if (n1 == '0) ng1 = 1'b0;
        if (n2 == '0) ng2 = 1'b0;
      end
      KIND_COMPLEX: begin
        n1 = MW'(sd.mb); ng1 = nbneg;
        n2 = MW'(s);     ng2 = 1'b0;
      end
      default: ;
    endcase
  end

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
    logic  use1;
    logic  use2;
  } dside_t;

  dside_t dsd_nxt;
  always_comb begin
    dsd_nxt.kind = sd.kind;
    dsd_nxt.neg1 = ng1 ^ (sd.kind == KIND_LINEAR ? sd.sb : sd.sa);
    dsd_nxt.neg2 = ng2 ^ sd.sa;
    dsd_nxt.use1 = (sd.kind != KIND_ALL) && (sd.kind != KIND_NONE);
    dsd_nxt.use2 = (sd.kind == KIND_TWO) || (sd.kind == KIND_COMPLEX);
  end

  logic [NW-1:0] dn1 [DVN+1];
  logic [NW-1:0] dn2 [DVN+1];
  logic [DW-1:0] dd1 [DVN+1];
  logic [DW-1:0] dd2 [DVN+1];
  logic [DW-1:0] dr1 [DVN+1];
  logic [DW-1:0] dr2 [DVN+1];
  dside_t        dsd [DVN+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dn1[0] <= {n1, {FRAC_BITS{1'b0}}};
      dn2[0] <= {n2, {FRAC_BITS{1'b0}}};
      dd1[0] <= den;
      dd2[0] <= den;
      dsd[0] <= dsd_nxt;
    end
  end
  assign dr1[0] = '0;
  assign dr2[0] = '0;

  for (genvar j = 0; j < DVN; j++) begin : g_dv
    qrs_div_cell #(.NW(NW), .DW(DW), .STEP(j)) u_d1 (
      .clk(clk), .en(adv),
      .num_i(dn1[j]), .den_i(dd1[j]), .rem_i(dr1[j]),
      .num_o(dn1[j+1]), .den_o(dd1[j+1]), .rem_o(dr1[j+1])
    );
    qrs_div_cell #(.NW(NW), .DW(DW), .STEP(j)) u_d2 (
      .clk(clk), .en(adv),
      .num_i(dn2[j]), .den_i(dd2[j]), .rem_i(dr2[j]),
      .num_o(dn2[j+1]), .den_o(dd2[j+1]), .rem_o(dr2[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) dsd[j+1] <= dsd[j];
    end
  end

  // saturation and output register
  localparam logic [NW-1:0] POS_MAX = NW'({1'b0, {(CW-1){1'b1}}});
  dside_t fs;
  logic [NW-1:0] q1, q2, lim1, lim2, m1, m2;
  logic o1, o2;
  logic [CW-1:0] r1, r2;
  always_comb begin
    fs   = dsd[DVN];
    q1   = dn1[DVN];
    q2   = dn2[DVN];
    lim1 = fs.neg1 ? POS_MAX + NW'(1) : POS_MAX;
    lim2 = fs.neg2 ? POS_MAX + NW'(1) : POS_MAX;
    o1   = fs.use1 && (q1 > lim1);
    o2   = fs.use2 && (q2 > lim2);
    m1   = o1 ? lim1 : q1;
    m2   = o2 ? lim2 : q2;
    r1   = fs.use1 ? CW'(fs.neg1 ? NW'(-m1) : m1) : '0;
    r2   = fs.use2 ? CW'(fs.neg2 ? NW'(-m2) : m2) : '0;
    if (fs.kind == KIND_DOUBLE) r2 = r1;
  end

  logic [KIND_W-1:0] kind_r;
  logic [CW-1:0] r1_r, r2_r;
  logic ovf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= fs.kind;
      r1_r   <= r1;
      r2_r   <= r2;
      ovf_r  <= o1 || o2;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = {kind_r, r1_r, r2_r, ovf_r};
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import qrs_pkg::*;

  localparam int CW = COEF_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1130;
  localparam int CYCLE_LIMIT = 400000;
  // drain margin on top of the pipe depth
  localparam int DRAIN = 2 * CW + FB + 40;

  typedef struct packed {
    kind_t         kind;
    logic [CW-1:0] root_one;
    logic [CW-1:0] root_two;
    logic          overflow;
  } roots_t;

  // Computes the expected roots of each accepted equation and holds them in order.
  class root_board;
    roots_t roots_due[$];

    static function logic [63:0] floor_sqrt(logic [127:0] n);
      logic [127:0] res, bitv, t;
      res = '0;
      bitv = 128'd1 << 126;
      for (int i = 0; i < 64; i++) begin
        t = res + bitv;
        if (n >= t) begin
          n = n - t;
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res[63:0];
    endfunction

    // num/den in Q format, truncated toward zero, saturated
    static function logic [CW-1:0] fix_div(bit nneg, logic [63:0] nmag, bit dneg,
                                           logic [63:0] dmag, inout bit ovf);
      logic [127:0] q, lim;
      bit neg;
      neg = nneg ^ dneg;
      q = ({64'd0, nmag} << FB) / {64'd0, dmag};
      lim = neg ? (128'd1 << (CW - 1)) : ((128'd1 << (CW - 1)) - 1);
      if (q > lim) begin
        q = lim;
        ovf = 1'b1;
      end
      return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    static function void split(logic [CW-1:0] v, output bit neg, output logic [63:0] mag);
      neg = v[CW-1];
      mag = neg ? ((64'd1 << CW) - {32'd0, v}) : {32'd0, v};
    endfunction

    function void note_equation(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
      roots_t r;
      bit sa, sb, sc, ovf, nb, sn;
      logic [63:0] ma, mb, mc, s, nm;
      logic [127:0] bsq, fac, dmag;
      bit dneg;
      split(a, sa, ma);
      split(b, sb, mb);
      split(c, sc, mc);
      ovf = 0;
      r.root_one = '0;
      r.root_two = '0;
      nb = !sb && mb != 0;  // sign of -b
      if (ma == 0) begin
        if (mb == 0) begin
          r.kind = (mc == 0) ? KIND_ALL : KIND_NONE;
        end else begin
          r.kind = KIND_LINEAR;
          r.root_one = fix_div(!sc && mc != 0, mc, sb, mb, ovf);
        end
      end else begin
        bsq = {64'd0, mb} * {64'd0, mb};
        fac = ({64'd0, ma} * {64'd0, mc}) << 2;
        dneg = 0;
        if (sa != sc || mc == 0) dmag = bsq + fac;
        else if (bsq >= fac) dmag = bsq - fac;
        else begin
          dmag = fac - bsq;
          dneg = 1;
        end
        if (dmag == 0) begin
          r.kind = KIND_DOUBLE;
          r.root_one = fix_div(nb, mb, sa, 2 * ma, ovf);
          r.root_two = r.root_one;
        end else if (!dneg) begin
          r.kind = KIND_TWO;
          s = floor_sqrt(dmag);
          // -b + s
          if (!nb) begin
            nm = mb + s; sn = 0;
          end else begin
            if (mb >= s) begin nm = mb - s; sn = 1; end
            else begin nm = s - mb; sn = 0; end
          end
          if (nm == 0) sn = 0;
          r.root_one = fix_div(sn, nm, sa, 2 * ma, ovf);
          // -b - s
          if (nb) begin
            nm = mb + s; sn = 1;
          end else begin
            if (mb >= s) begin nm = mb - s; sn = 0; end
            else begin nm = s - mb; sn = 1; end
          end
          if (nm == 0) sn = 0;
          r.root_two = fix_div(sn, nm, sa, 2 * ma, ovf);
        end else begin
          r.kind = KIND_COMPLEX;
          s = floor_sqrt(dmag);
          r.root_one = fix_div(nb, mb, sa, 2 * ma, ovf);
          r.root_two = fix_div(0, s, sa, 2 * ma, ovf);
        end
      end
      r.overflow = ovf;
      roots_due.push_back(r);
    endfunction

    // returns an empty string when the beat matches the oldest expectation
    function string check_roots(roots_t got);
      roots_t e;
      string msg;
      if (roots_due.size() == 0) return $sformatf("unexpected result beat %p", got);
      e = roots_due.pop_front();
      msg = "";
      if (got.kind !== e.kind)
        msg = {msg, $sformatf(" kind got %0d exp %0d", got.kind, e.kind)};
      if (got.root_one !== e.root_one)
        msg = {msg, $sformatf(" root_one got %h exp %h", got.root_one, e.root_one)};
      if (got.root_two !== e.root_two)
        msg = {msg, $sformatf(" root_two got %h exp %h", got.root_two, e.root_two)};
      if (got.overflow !== e.overflow)
        msg = {msg, $sformatf(" overflow got %b exp %b", got.overflow, e.overflow)};
      return msg;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  qrs_if #(.W(3 * CW)) in_ch ();
  qrs_if #(.W(3 + 2 * CW + 1)) out_ch ();

  quadratic_root_solver u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  root_board board = new();
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;   // stretch with no idling on either side
  int stall = 0;

  task automatic report(string msg);
    $display("MISMATCH @%0t:%s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // input monitor: every accepted beat gets its expectation
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_equation(in_ch.data[3*CW-1 -: CW], in_ch.data[2*CW-1 -: CW],
                          in_ch.data[CW-1:0]);
  end

  // result sink: check each beat, then hold ready low for a drawn stall
  always @(posedge clk) begin
    string msg;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        msg = board.check_roots(roots_t'(out_ch.data));
        if (msg != "") report(msg);
        stall = quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_eq(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= {a, b, c};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // signed raw value in [-lim, lim]
  function automatic logic [CW-1:0] near_zero(int lim);
    return CW'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // zero, most negative or most positive
  function automatic logic [CW-1:0] extreme();
    if ($urandom_range(0, 2) == 0) return '0;
    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  task automatic send_random();
    logic [CW-1:0] a, b, c;
    int u, t;
    case ($urandom_range(0, 9))
      0, 1: begin  // full range
        a = $urandom; b = $urandom; c = $urandom;
      end
      2, 3, 4: begin  // coefficients within about +-4.0
        a = near_zero(1 << 18); b = near_zero(1 << 18); c = near_zero(1 << 18);
      end
      5, 6: begin  // built double root: b*b == 4*a*c
        u = $urandom_range(1, 255);
        t = $urandom_range(0, 4000) - 2000;
        if ($urandom_range(0, 1)) u = -u;
        a = CW'(u); b = CW'(2 * u * t); c = CW'(u * t * t);
      end
      7: begin  // no quadratic term
        a = 0; b = $urandom_range(0, 3) == 0 ? 0 : near_zero(1 << 20); c = $urandom;
      end
      8: begin  // tiny a so roots overflow
        a = near_zero(4); b = $urandom; c = near_zero(1 << 20);
      end
      default: begin  // extremes mixed with zero
        a = extreme();
        b = extreme();
        c = extreme();
      end
    endcase
    send_eq(a, b, c);
  endtask

  localparam logic [CW-1:0] ONE = 32'h0001_0000;
  localparam logic [CW-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [CW-1:0] MINV = 32'h8000_0000;

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each solution kind, signs, extremes and saturation
    send_eq(0, 0, 0);                      // every x solves
    send_eq(0, 0, ONE);                    // only c nonzero: no solution
    send_eq(0, 2 * ONE, -4 * ONE);         // linear root 2
    send_eq(0, -ONE, 0);                   // linear root of zero, no negative zero
    send_eq(ONE, 2 * ONE, ONE);            // double root -1
    send_eq(ONE, 0, 0);                    // double root at zero
    send_eq(ONE, -3 * ONE, 2 * ONE);       // two real roots 2 and 1
    send_eq(-ONE, 0, 4 * ONE);             // negative a, roots -2 and 2
    send_eq(ONE, 0, ONE);                  // complex pair 0 +- i
    send_eq(-ONE, 2 * ONE, -5 * ONE);      // complex pair, negative a
    send_eq(ONE, ONE, 0);                  // one zero root
    send_eq(MAXV, MAXV, MAXV);
    send_eq(MINV, MINV, MINV);
    send_eq(MINV, MAXV, MINV);
    send_eq(MAXV, MINV, 0);
    send_eq(1, MAXV, 0);                   // tiny a: root saturates
    send_eq(-1, MINV, 1);
    send_eq(0, 1, MAXV);                   // linear overflow
    send_eq(0, -1, MAXV);
    send_eq(0, MINV, MINV);
    send_eq(1, 2, 1);                      // smallest double root
    send_eq(MINV, 0, MAXV);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random();
    end
    in_ch.valid <= 1'b0;

    while (board.roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
